// ----- hw/rtl/smp_pkg.sv -----
// Package for the skinning matrix palette: request and result types, matrix word
// layout and the fixed-point element helper. No dependencies.
package smp_pkg;

  localparam int unsigned WORDS = 6;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_POSE = 1'b1
  } func_t;

  typedef enum logic {
    KIND_MODEL = 1'b0,
    KIND_SKIN  = 1'b1
  } kind_t;

  typedef struct packed {
    func_t       func;
    logic [5:0]  bone_index;
    logic [5:0]  parent_bone;
    logic        is_root;
    logic [63:0] p_r0_left;
    logic [63:0] p_r0_right;
    logic [63:0] p_r1_left;
    logic [63:0] p_r1_right;
    logic [63:0] p_r2_left;
    logic [63:0] p_r2_right;
  } req_t;

  typedef struct packed {
    logic [5:0]  out_bone;
    kind_t       matrix_kind;
    logic        last_of_bone;
    logic        error;
    logic [63:0] m_r0_left;
    logic [63:0] m_r0_right;
    logic [63:0] m_r1_left;
    logic [63:0] m_r1_right;
    logic [63:0] m_r2_left;
    logic [63:0] m_r2_right;
  } rsp_t;

  // Word 0 is row 0 left, word 5 is row 2 right.
  typedef logic [WORDS-1:0][63:0] mat_words_t;

  function automatic logic signed [31:0] elem(mat_words_t m, logic [1:0] r, logic [1:0] c);
    logic [2:0] w;
    w = 3'({r, 1'b0}) + 3'(c[1]);
    return m[w][{c[0], 5'd0} +: 32];
  endfunction

endpackage

// ----- hw/rtl/skinning_matrix_palette_top.sv -----
// Skinning matrix palette: load inverse-bind matrices, pose bones and emit model and
// skinning matrices. Depends on smp_pkg.
// A load request is accepted and then writes its six words to the inverse-bind store.
// A pose request is accepted, reads the parent model and inverse-bind words, forms
// each 3x4 product through the three-multiplier element unit and writes the model
// words back, then issues one result per cycle while the result side does not stall.
// A root or bad-parent pose skips the first product.
// Requests are taken one at a time. Reset is synchronous; the stores hold no reset value.
module skinning_matrix_palette_top
  import smp_pkg::*;
#(
  parameter int unsigned BONE_LIMIT    = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned DEPTH = BONE_LIMIT * WORDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = 67;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WRI  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_WRM  = 7'b0010000,
    S_OUTM = 7'b0100000,
    S_OUTS = 7'b1000000
  } state_t;

  state_t state;

  logic [63:0] model_mem [DEPTH];
  logic [63:0] inv_mem [DEPTH];
  logic [63:0] model_q;
  logic [63:0] inv_q;

  req_t       cur;
  mat_words_t pp;
  mat_words_t pm;
  mat_words_t iv;
  mat_words_t mdl;
  mat_words_t skn;
  logic       err;
  logic       phase;
  logic [3:0] cnt;
  logic [1:0] ri;
  logic [1:0] ci;
  logic       rd_valid;
  logic [2:0] rd_w;

  logic signed [63:0] prod [3];
  logic signed [63:0] trans;
  logic               v1;
  logic [1:0]         ri1;
  logic [1:0]         ci1;

  logic            accept;
  logic            in_range;
  logic [9:0]      bone_base;
  logic [9:0]      par_base;
  logic [AW-1:0]   bone_addr;
  logic [AW-1:0]   par_addr;
  logic            rsp_free;
  mat_words_t      opa;
  mat_words_t      opb;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic [31:0]     sat;
  logic            mwr_en;
  logic            iwr_en;
  logic [AW-1:0]   wr_addr;
  logic [63:0]     mwr_data;
  logic [63:0]     iwr_data;
  logic            rd_en;
  logic [AW-1:0]   mrd_addr;
  logic [AW-1:0]   ird_addr;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign in_range  = (32'(req.bone_index) < BONE_LIMIT);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign bone_base = {2'b00, cur.bone_index, 2'b00} + {3'b000, cur.bone_index, 1'b0};
  assign par_base  = {2'b00, cur.parent_bone, 2'b00} + {3'b000, cur.parent_bone, 1'b0};
  assign bone_addr = AW'(bone_base + 10'(cnt[2:0]));
  assign par_addr  = AW'(par_base + 10'(cnt[2:0]));

  assign opa = phase ? mdl : pm;
  assign opb = phase ? iv : pp;

  assign rd_en    = (state == S_RD) && (cnt < 4'(WORDS));
  assign mrd_addr = par_addr;
  assign ird_addr = bone_addr;
  assign wr_addr  = bone_addr;
  assign iwr_en   = (state == S_WRI);
  assign mwr_en   = (state == S_WRM);
  assign iwr_data = pp[cnt[2:0]];
  assign mwr_data = mdl[cnt[2:0]];

  always_ff @(posedge clk) begin
    if (mwr_en) begin
      model_mem[wr_addr] <= mwr_data;
    end
    if (rd_en) begin
      model_q <= model_mem[mrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (iwr_en) begin
      inv_mem[wr_addr] <= iwr_data;
    end
    if (rd_en) begin
      inv_q <= inv_mem[ird_addr];
    end
  end

  always_comb begin
    sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(trans)
        + (SW'(1) <<< (FRACTION_BITS - 1));
    shifted = sum >>> FRACTION_BITS;
    if (shifted > SW'(64'sh7fffffff)) begin
      sat = 32'h7fffffff;
    end else if (shifted < -SW'(64'sh80000000)) begin
      sat = 32'h80000000;
    end else begin
      sat = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    v1  <= (state == S_MUL) && (cnt < 4'd12);
    ri1 <= ri;
    ci1 <= ci;
    for (int k = 0; k < 3; k++) begin
      prod[k] <= 64'(elem(opa, ri, 2'(k))) * 64'(elem(opb, 2'(k), ci));
    end
    if (ci == 2'd3) begin
      trans <= 64'(elem(opa, ri, 2'd3)) <<< FRACTION_BITS;
    end else begin
      trans <= '0;
    end
    rd_valid <= rd_en;
    rd_w     <= cnt[2:0];
    if (rd_valid) begin
      pm[rd_w] <= model_q;
      iv[rd_w] <= inv_q;
    end
    if (v1) begin
      if (phase) begin
        skn[3'({ri1, 1'b0}) + 3'(ci1[1])][{ci1[0], 5'd0} +: 32] <= sat;
      end else begin
        mdl[3'({ri1, 1'b0}) + 3'(ci1[1])][{ci1[0], 5'd0} +: 32] <= sat;
      end
    end
    if (state == S_RD && cnt == 4'(WORDS) && (cur.is_root || err)) begin
      mdl <= pp;
    end
    if (accept) begin
      cur <= req;
      pp  <= {req.p_r2_right, req.p_r2_left, req.p_r1_right, req.p_r1_left,
              req.p_r0_right, req.p_r0_left};
      err <= !req.is_root && (req.parent_bone >= req.bone_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ri        <= '0;
      ci        <= '0;
      phase     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_OUTM && state != S_OUTS) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt   <= '0;
          ri    <= '0;
          ci    <= '0;
          phase <= 1'b0;
          if (accept && in_range) begin
            state <= (req.func == FUNC_LOAD) ? S_WRI : S_RD;
          end
        end
        S_WRI: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(WORDS)) begin
            cnt   <= '0;
            state <= (cur.is_root || err) ? S_WRM : S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 4'd1;
          ci  <= ci + 2'd1;
          if (ci == 2'd3) begin
            ri <= ri + 2'd1;
          end
          if (cnt == 4'd12) begin
            cnt   <= '0;
            ri    <= '0;
            ci    <= '0;
            state <= phase ? S_OUTM : S_WRM;
          end
        end
        S_WRM: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'(WORDS - 1)) begin
            cnt   <= '0;
            phase <= 1'b1;
            state <= S_MUL;
          end
        end
        S_OUTM: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp <= '{out_bone: cur.bone_index, matrix_kind: KIND_MODEL, last_of_bone: 1'b0,
                     error: err, m_r0_left: mdl[0], m_r0_right: mdl[1],
                     m_r1_left: mdl[2], m_r1_right: mdl[3],
                     m_r2_left: mdl[4], m_r2_right: mdl[5]};
            state <= S_OUTS;
          end
        end
        S_OUTS: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp <= '{out_bone: cur.bone_index, matrix_kind: KIND_SKIN, last_of_bone: 1'b1,
                     error: err, m_r0_left: skn[0], m_r0_right: skn[1],
                     m_r1_left: skn[2], m_r1_right: skn[3],
                     m_r2_left: skn[4], m_r2_right: skn[5]};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL && cnt < 4'd12 |-> ri != 2'd3)
    else $error("Element row counter ran past the last row.");

  a_wrm_pose: assert property (@(posedge clk) disable iff (rst)
    state == S_WRM |-> cur.func == FUNC_POSE)
    else $error("Model write-back for a load request.");

  a_skin_after_model: assert property (@(posedge clk) disable iff (rst)
    state == S_OUTS |-> $past(state) == S_OUTS || $past(state) == S_OUTM)
    else $error("Skinning result issued without its model result.");

  a_skin_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.matrix_kind == KIND_SKIN |-> rsp.last_of_bone)
    else $error("Skinning result not marked as last of its bone.");

endmodule

// ----- bench/smp_palette_monitor.sv -----
// Watches both channels of the skinning matrix palette, predicts every result from the
// accepted requests and compares them field by field. Depends on smp_pkg.
module smp_palette_monitor
  import smp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fails,
  output int   pending
);

  localparam int FRAC = 16;

  mat_words_t model_mem [64];
  mat_words_t inv_bind_mem [64];
  rsp_t       expected_rsps [$];

  initial fails = 0;
  assign pending = expected_rsps.size();

  function automatic logic signed [31:0] element_of(mat_words_t m, int r, int c);
    return m[2 * r + c / 2][(c % 2) * 32 +: 32];
  endfunction

  function automatic mat_words_t affine_product(mat_words_t a, mat_words_t b);
    mat_words_t         res;
    logic signed [79:0] acc;
    logic signed [79:0] ea;
    logic signed [79:0] eb;
    logic signed [31:0] r32;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          ea = element_of(a, i, k);
          eb = element_of(b, k, j);
          acc = acc + ea * eb;
        end
        if (j == 3) begin
          ea = element_of(a, i, 3);
          acc = acc + (ea <<< FRAC);
        end
        acc = (acc + (80'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (acc > 80'sh7fffffff) r32 = 32'h7fffffff;
        else if (acc < -80'sh80000000) r32 = 32'h80000000;
        else r32 = acc[31:0];
        res[2 * i + j / 2][(j % 2) * 32 +: 32] = r32;
      end
    end
    return res;
  endfunction

  function automatic mat_words_t words_of(req_t q);
    mat_words_t w;
    w[0] = q.p_r0_left;
    w[1] = q.p_r0_right;
    w[2] = q.p_r1_left;
    w[3] = q.p_r1_right;
    w[4] = q.p_r2_left;
    w[5] = q.p_r2_right;
    return w;
  endfunction

  function automatic rsp_t make_result(logic [5:0] bone, kind_t kind, logic err,
                                       mat_words_t m);
    rsp_t o;
    o.out_bone     = bone;
    o.matrix_kind  = kind;
    o.last_of_bone = (kind == KIND_SKIN);
    o.error        = err;
    o.m_r0_left    = m[0];
    o.m_r0_right   = m[1];
    o.m_r1_left    = m[2];
    o.m_r1_right   = m[3];
    o.m_r2_left    = m[4];
    o.m_r2_right   = m[5];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fails++;
  endtask

  task automatic predict_pose(req_t q);
    mat_words_t p;
    mat_words_t m;
    logic       err;
    p = words_of(q);
    err = !q.is_root && (q.parent_bone >= q.bone_index);
    if (q.is_root || err) m = p;
    else m = affine_product(model_mem[q.parent_bone], p);
    model_mem[q.bone_index] = m;
    expected_rsps.push_back(make_result(q.bone_index, KIND_MODEL, err, m));
    expected_rsps.push_back(make_result(q.bone_index, KIND_SKIN, err,
                                        affine_product(m, inv_bind_mem[q.bone_index])));
  endtask

  task automatic compare_result(rsp_t r);
    rsp_t e;
    if (expected_rsps.size() == 0) begin
      report("unexpected result, bone", 64'(r.out_bone), '0);
      return;
    end
    e = expected_rsps.pop_front();
    if (r.out_bone !== e.out_bone)
      report("out_bone", 64'(r.out_bone), 64'(e.out_bone));
    if (r.matrix_kind !== e.matrix_kind)
      report("matrix_kind", 64'(r.matrix_kind), 64'(e.matrix_kind));
    if (r.last_of_bone !== e.last_of_bone)
      report("last_of_bone", 64'(r.last_of_bone), 64'(e.last_of_bone));
    if (r.error !== e.error) report("error", 64'(r.error), 64'(e.error));
    if (r.m_r0_left !== e.m_r0_left) report("m_r0_left", r.m_r0_left, e.m_r0_left);
    if (r.m_r0_right !== e.m_r0_right) report("m_r0_right", r.m_r0_right, e.m_r0_right);
    if (r.m_r1_left !== e.m_r1_left) report("m_r1_left", r.m_r1_left, e.m_r1_left);
    if (r.m_r1_right !== e.m_r1_right) report("m_r1_right", r.m_r1_right, e.m_r1_right);
    if (r.m_r2_left !== e.m_r2_left) report("m_r2_left", r.m_r2_left, e.m_r2_left);
    if (r.m_r2_right !== e.m_r2_right) report("m_r2_right", r.m_r2_right, e.m_r2_right);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        if (req.func == FUNC_LOAD) inv_bind_mem[req.bone_index] = words_of(req);
        else predict_pose(req);
      end
      if (rsp_valid && !rsp_stall) compare_result(rsp);
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the skinning matrix palette: clock, reset, request stimulus and
// result-side stalls, with the verdict. Depends on smp_pkg and smp_palette_monitor.
module tb_top;
  import smp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  req_t req = '0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;
  int   fails;
  int   pending;

  int tx_pct = 0;
  int rx_pct = 0;
  bit hold_on = 1'b0;
  int hold_cnt = 0;
  bit inv_bind_ok [64];
  bit model_ok [64];

  always #5 clk = ~clk;

  skinning_matrix_palette_top u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  smp_palette_monitor u_palette_mon (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fails(fails), .pending(pending)
  );

  // The long hold-off is counted here, independently of the request process.
  always @(posedge clk) begin
    if (hold_on) begin
      rsp_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= 400) begin
        hold_on = 1'b0;
        hold_cnt = 0;
      end
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3, 4: return 32'($urandom_range(262143)) - 32'd131072;
      default: return $urandom_range(1) ? 32'h00010000 : 32'h0;
    endcase
  endfunction

  function automatic mat_words_t rand_mat();
    mat_words_t m;
    for (int w = 0; w < WORDS; w++) m[w] = {rand_elem(), rand_elem()};
    return m;
  endfunction

  function automatic mat_words_t fill_mat(logic [31:0] v);
    mat_words_t m;
    for (int w = 0; w < WORDS; w++) m[w] = {v, v};
    return m;
  endfunction

  task automatic send(func_t f, int bone, int parent, bit root, mat_words_t m);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct && gap < 20) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.func         <= f;
    req.bone_index   <= 6'(bone);
    req.parent_bone  <= 6'(parent);
    req.is_root      <= root;
    req.p_r0_left    <= m[0];
    req.p_r0_right   <= m[1];
    req.p_r1_left    <= m[2];
    req.p_r1_right   <= m[3];
    req.p_r2_left    <= m[4];
    req.p_r2_right   <= m[5];
    req_valid        <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (f == FUNC_LOAD) inv_bind_ok[bone] = 1'b1;
    else model_ok[bone] = 1'b1;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_step();
    int bone;
    int parent;
    int roll;
    int cands [$];
    bone = $urandom_range(63);
    roll = $urandom_range(99);
    if (roll < 10 || !inv_bind_ok[bone]) begin
      send(FUNC_LOAD, bone, $urandom_range(63), $urandom_range(1), rand_mat());
      if (roll < 10) return;
    end
    for (int i = 0; i < bone; i++) if (model_ok[i]) cands.push_back(i);
    if (roll < 75 && cands.size() > 0) begin
      parent = cands[$urandom_range(cands.size() - 1)];
      send(FUNC_POSE, bone, parent, 1'b0, rand_mat());
    end else if (roll < 85) begin
      send(FUNC_POSE, bone, $urandom_range(63, bone), 1'b0, rand_mat());
    end else begin
      send(FUNC_POSE, bone, $urandom_range(63), 1'b1, rand_mat());
    end
  endtask

  initial begin
    mat_words_t ident;
    ident = '0;
    ident[0][31:0]  = 32'h00010000;
    ident[2][63:32] = 32'h00010000;
    ident[5][31:0]  = 32'h00010000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FUNC_LOAD, 0, 0, 1'b0, ident);
    send(FUNC_LOAD, 1, 0, 1'b0, fill_mat(32'h7fffffff));
    send(FUNC_LOAD, 2, 0, 1'b0, fill_mat(32'h80000000));
    send(FUNC_LOAD, 3, 0, 1'b0, fill_mat(32'hffffffff));
    send(FUNC_LOAD, 4, 0, 1'b0, '0);
    send(FUNC_LOAD, 63, 63, 1'b1, fill_mat(32'h00018000));
    send(FUNC_POSE, 0, 63, 1'b1, rand_mat());
    send(FUNC_POSE, 1, 0, 1'b0, fill_mat(32'h7fffffff));
    send(FUNC_POSE, 2, 1, 1'b0, fill_mat(32'h80000000));
    send(FUNC_POSE, 3, 3, 1'b0, fill_mat(32'hffffffff));
    send(FUNC_POSE, 4, 60, 1'b0, ident);
    send(FUNC_POSE, 0, 0, 1'b0, ident);
    send(FUNC_POSE, 63, 63, 1'b1, fill_mat(32'hffffffff));
    send(FUNC_POSE, 63, 2, 1'b0, fill_mat(32'h00008000));
    drain();

    tx_pct = 34;
    rx_pct = 68;
    hold_on = 1'b1;
    for (int n = 0; n < 330; n++) random_step();
    drain();

    tx_pct = 68;
    rx_pct = 34;
    for (int n = 0; n < 330; n++) random_step();
    drain();

    tx_pct = 0;
    rx_pct = 0;
    for (int n = 0; n < 330; n++) random_step();
    drain();

    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/smp_pkg.sv
hw/rtl/skinning_matrix_palette_top.sv
bench/smp_palette_monitor.sv
bench/tb_top.sv
